### hdl/alp_pkg.sv
package alp_pkg;

  localparam int MAC_W      = 48;
  localparam int ADDR_W     = 32;
  localparam int LEASE_W    = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // register reset values: 192.8.1.2 and a lease of 120 ticks
  localparam logic [ADDR_W-1:0]  POOL_BASE_RST    = 32'hC008_0102;
  localparam logic [LEASE_W-1:0] LEASE_LENGTH_RST = 16'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_BASE      = 8'd0,
    REG_LEASE_LENGTH   = 8'd1,
    REG_SERVER_ADDRESS = 8'd2,
    REG_PREFIX_LENGTH  = 8'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_DISCOVER = 2'd0,
    CMD_REQUEST  = 2'd1,
    CMD_RENEW    = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RK_OFFER     = 2'd0,
    RK_ACK       = 2'd1,
    RK_EXHAUSTED = 2'd2
  } reply_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_PROBE,
    ST_SCAN,
    ST_LOOK,
    ST_TICK,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic [MAC_W-1:0]   owner_mac;
    logic [LEASE_W-1:0] lease_left;
    logic               in_use;
    logic               offered;
  } entry_t;

  typedef struct packed {
    reply_kind_t        kind;
    logic [MAC_W-1:0]   mac;
    logic [ADDR_W-1:0]  address;
    logic [LEASE_W-1:0] lease;
  } reply_t;

endpackage

### hdl/address_lease_pool.sv
// address lease pool: hands out addresses pool_base + k to clients
// input channel (in_*): one command per transfer, kind in in_tuser
//   discover gives an offer or a pool-exhausted reply, request gives an
//   acknowledge when the entry was offered to that client, renew and tick
//   give no reply
// output channel (out_*): one reply per discover or successful request
// cfg_* port: register writes, to be issued only while the block is idle
// per-entry state sits in one synchronous entry store, read in the cycle
//   before its write-back; the controller walks it one entry a cycle
// what each command does in the entry store, with a ready receiver:
//   request: a read, and a write when acknowledged; renew: a read, and a
//   write when the owner matches; an address outside the pool: no read
//   discover: probes the asked-for entry, scanning the entry store from
//     entry 0 when it is not free or no address in the pool was asked for
//   tick: one entry read-modify-written per cycle
// reset clears the control state and the valid bits of the store, so every
//   entry reads as free with a zero lease; there is no clearing pass
// a reply waits in the output register; a stalled receiver holds the next
//   reply in the controller and stops further input only then
module address_lease_pool #(
  parameter int POOL_ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // client_mac [47:0], wanted_address [79:48]
  input  logic [79:0]                       in_tdata,
  // command [1:0]
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // reply_mac [47:0], given_address [79:48], lease_ticks [95:80]
  output logic [95:0]                       out_tdata,
  // reply_kind [1:0]
  output logic [1:0]                        out_tuser,
  input  logic                              cfg_wr_en,
  input  logic [alp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [alp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import alp_pkg::*;

  localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;

  logic [ADDR_W-1:0]  pool_base_r;
  logic [LEASE_W-1:0] lease_length_r;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  entry_t             rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  entry_t             wr_data;

  logic               rep_valid;
  logic               rep_ready;
  reply_t             rep;

  logic               out_valid_r;
  reply_t             out_rep_r;

  // configuration registers; server address and prefix length are not held here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r    <= POOL_BASE_RST;
      lease_length_r <= LEASE_LENGTH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_POOL_BASE:      pool_base_r    <= cfg_wdata[ADDR_W-1:0];
        REG_LEASE_LENGTH:   lease_length_r <= cfg_wdata[LEASE_W-1:0];
        REG_SERVER_ADDRESS: ;
        REG_PREFIX_LENGTH:  ;
        default:            ;
      endcase
    end
  end

  alp_ctrl #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_cmd       (cmd_t'(in_tuser)),
    .in_mac       (in_tdata[MAC_W-1:0]),
    .in_want      (in_tdata[MAC_W+ADDR_W-1:MAC_W]),
    .pool_base    (pool_base_r),
    .lease_length (lease_length_r),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rep_valid    (rep_valid),
    .rep_ready    (rep_ready),
    .rep          (rep)
  );

  alp_store #(
    .DEPTH   (POOL_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // output register, refilled in the cycle the previous reply is taken
  assign rep_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rep_ready) begin
      out_valid_r <= rep_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rep_valid && rep_ready) begin
      out_rep_r <= rep;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_rep_r.lease, out_rep_r.address, out_rep_r.mac};
  assign out_tuser  = out_rep_r.kind;

`ifndef NO_ASSERTIONS
  // the sequencer never reads back the entry it is writing
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("entry store read and write hit the same entry");

  // store writes only happen while a command is being worked on
  a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !in_tready)
    else $error("entry store written while idle");

  // exhausted replies carry neither address nor lease
  a_exhausted_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == RK_EXHAUSTED)) |-> (out_tdata[95:48] == '0))
    else $error("exhausted reply with address or lease");

  // offers never grant a lease
  a_offer_no_lease: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == RK_OFFER)) |-> (out_tdata[95:80] == '0))
    else $error("offer carries a lease");
`endif

endmodule

### hdl/alp_store.sv
module alp_store #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output alp_pkg::entry_t     rd_data,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  alp_pkg::entry_t     wr_data
);
  import alp_pkg::*;

  entry_t             mem_r [DEPTH];
  logic [DEPTH-1:0]   valid_r;
  entry_t             rd_q_r;
  logic               rd_vld_r;

  // entry store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r   <= mem_r[rd_addr];
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // an entry never written since reset reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

### hdl/alp_ctrl.sv
module alp_ctrl #(
  parameter int POOL_ENTRIES = 16,
  parameter int IDX_W        = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  alp_pkg::cmd_t                 in_cmd,
  input  logic [alp_pkg::MAC_W-1:0]     in_mac,
  input  logic [alp_pkg::ADDR_W-1:0]    in_want,
  input  logic [alp_pkg::ADDR_W-1:0]    pool_base,
  input  logic [alp_pkg::LEASE_W-1:0]   lease_length,
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr,
  input  alp_pkg::entry_t               rd_data,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output alp_pkg::entry_t               wr_data,
  output logic                          rep_valid,
  input  logic                          rep_ready,
  output alp_pkg::reply_t               rep
);
  import alp_pkg::*;

  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(POOL_ENTRIES - 1);
  localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(POOL_ENTRIES);

  state_t               state_r,   state_nxt;
  cmd_t                 cmd_r,     cmd_nxt;
  logic [MAC_W-1:0]     mac_r,     mac_nxt;
  logic                 want_nz_r, want_nz_nxt;
  logic                 hit_r,     hit_nxt;
  logic [IDX_W-1:0]     idx_r,     idx_nxt;
  reply_t               rep_r,     rep_nxt;

  logic [ADDR_W-1:0]    offset;
  logic [ADDR_W-1:0]    entry_addr;
  logic                 entry_free;
  logic [LEASE_W:0]     renew_sum;
  entry_t               offer_entry;

  assign offset      = in_want - pool_base;
  assign entry_addr  = pool_base + ADDR_W'(idx_r);
  assign entry_free  = !rd_data.in_use && !rd_data.offered;
  assign renew_sum   = {1'b0, rd_data.lease_left} + {1'b0, lease_length};

  always_comb begin
    offer_entry           = rd_data;
    offer_entry.offered   = 1'b1;
    offer_entry.owner_mac = mac_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    mac_r     <= mac_nxt;
    want_nz_r <= want_nz_nxt;
    hit_r     <= hit_nxt;
    idx_r     <= idx_nxt;
    rep_r     <= rep_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    mac_nxt     = mac_r;
    want_nz_nxt = want_nz_r;
    hit_nxt     = hit_r;
    idx_nxt     = idx_r;
    rep_nxt     = rep_r;
    in_ready    = (state_r == ST_IDLE);
    rd_en       = 1'b0;
    rd_addr     = idx_r;
    wr_en       = 1'b0;
    wr_addr     = idx_r;
    wr_data     = rd_data;
    rep_valid   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt     = in_cmd;
          mac_nxt     = in_mac;
          want_nz_nxt = (in_want != '0);
          hit_nxt     = (offset < DEPTH_A);
          idx_nxt     = offset[IDX_W-1:0];
          state_nxt   = ST_ISSUE;
        end
      end

      ST_ISSUE: begin
        unique case (cmd_r)
          CMD_DISCOVER: begin
            rd_en = 1'b1;
            if (want_nz_r && hit_r) begin
              state_nxt = ST_PROBE;
            end else begin
              rd_addr   = '0;
              idx_nxt   = '0;
              state_nxt = ST_SCAN;
            end
          end
          CMD_REQUEST, CMD_RENEW: begin
            if (hit_r) begin
              rd_en     = 1'b1;
              state_nxt = ST_LOOK;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
          CMD_TICK: begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            idx_nxt   = '0;
            state_nxt = ST_TICK;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end

      // asked-for entry has come back
      ST_PROBE: begin
        if (entry_free) begin
          wr_en     = 1'b1;
          wr_data   = offer_entry;
          rep_nxt   = '{RK_OFFER, mac_r, entry_addr, '0};
          state_nxt = ST_REPLY;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = '0;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end

      // first free entry, one entry per cycle
      ST_SCAN: begin
        if (entry_free) begin
          wr_en     = 1'b1;
          wr_data   = offer_entry;
          rep_nxt   = '{RK_OFFER, mac_r, entry_addr, '0};
          state_nxt = ST_REPLY;
        end else if (idx_r == LAST_IDX) begin
          rep_nxt   = '{RK_EXHAUSTED, mac_r, '0, '0};
          state_nxt = ST_REPLY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_LOOK: begin
        state_nxt = ST_IDLE;
        if (cmd_r == CMD_REQUEST) begin
          if (rd_data.owner_mac == mac_r && !rd_data.in_use && rd_data.offered) begin
            wr_en              = 1'b1;
            wr_data.lease_left = lease_length;
            wr_data.in_use     = 1'b1;
            wr_data.offered    = 1'b0;
            rep_nxt   = '{RK_ACK, rd_data.owner_mac, entry_addr, lease_length};
            state_nxt = ST_REPLY;
          end
        end else if (rd_data.owner_mac == mac_r) begin
          wr_en              = 1'b1;
          wr_data.lease_left = renew_sum[LEASE_W] ? '1 : renew_sum[LEASE_W-1:0];
        end
      end

      // count down every active lease and free an entry whose lease runs out; write back behind the read
      ST_TICK: begin
        if (rd_data.in_use) begin
          wr_en = 1'b1;
          if (rd_data.lease_left <= LEASE_W'(1)) begin
            wr_data = '0;
          end else begin
            wr_data.lease_left = rd_data.lease_left - 1'b1;
          end
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end

      ST_REPLY: begin
        rep_valid = 1'b1;
        if (rep_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  assign rep = rep_r;

endmodule
